/* design/charger_telemetry_decode_macros.svh */
// ---------------------------------------------------------------------------
// charger telemetry decode assertion macros
// shared property wrappers for the checker
// ---------------------------------------------------------------------------
`ifndef CHARGER_TELEMETRY_DECODE_MACROS_SVH
`define CHARGER_TELEMETRY_DECODE_MACROS_SVH

// property checked only out of reset
`define CTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CTD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ctd_pkg.sv */
// ---------------------------------------------------------------------------
// ctd_pkg
// types, constants and lookup functions for the charger telemetry decoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctd_pkg;

  localparam int unsigned SOC_FIRST_INNER = 1;
  localparam int unsigned SOC_LAST_INNER  = 19;
  localparam int unsigned SOC_SUBSTEPS    = 5;

  localparam logic [12:0] SOC_EMPTY_MV = 13'd3270;
  localparam logic [12:0] SOC_FULL_MV  = 13'd4200;
  localparam logic [6:0]  PCT_EMPTY    = 7'd0;
  localparam logic [6:0]  PCT_FULL     = 7'd100;

  localparam logic [12:0] MV_PER_VCODE  = 13'd20;
  localparam logic [12:0] MV_PER_VIN    = 13'd60;
  localparam logic [15:0] ICHG_SCALE    = 16'd175;
  localparam logic [15:0] IIN_SCALE     = 16'd133;
  localparam logic [11:0] MA_PER_LIMIT  = 12'd50;

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
  localparam logic [31:0] RECIP_TEN   = 32'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic [2:0] input_state;
    logic [1:0] charge_state;
    logic [2:0] fault_bits;
    logic [2:0] ntc_state;
    logic [1:0] ppm_bits;
  } ctd_flags_t;

  typedef struct packed {
    ctd_flags_t  flags;
    logic [12:0] battery_mv;
    logic [12:0] system_mv;
    logic [12:0] input_mv;
    logic [15:0] ichg_prod;
    logic [15:0] iin_prod;
    logic [11:0] limit_ma;
  } ctd_s1_t;

  typedef struct packed {
    ctd_flags_t  flags;
    logic [12:0] battery_mv;
    logic [12:0] system_mv;
    logic [12:0] input_mv;
    logic [31:0] ichg_recip;
    logic [31:0] iin_recip;
    logic [11:0] limit_ma;
    logic        below;
    logic        full;
    logic [4:0]  seg;
    logic [8:0]  offset;
  } ctd_s2_t;

  function automatic logic [12:0] soc_point(input logic [4:0] idx);
    logic [12:0] mv;
    case (idx)
      5'd0:    mv = 13'd3270;
      5'd1:    mv = 13'd3610;
      5'd2:    mv = 13'd3690;
      5'd3:    mv = 13'd3710;
      5'd4:    mv = 13'd3730;
      5'd5:    mv = 13'd3750;
      5'd6:    mv = 13'd3770;
      5'd7:    mv = 13'd3790;
      5'd8:    mv = 13'd3800;
      5'd9:    mv = 13'd3820;
      5'd10:   mv = 13'd3840;
      5'd11:   mv = 13'd3850;
      5'd12:   mv = 13'd3870;
      5'd13:   mv = 13'd3910;
      5'd14:   mv = 13'd3950;
      5'd15:   mv = 13'd3980;
      5'd16:   mv = 13'd4020;
      5'd17:   mv = 13'd4080;
      5'd18:   mv = 13'd4110;
      5'd19:   mv = 13'd4150;
      5'd20:   mv = 13'd4200;
      default: mv = 13'd4200;
    endcase
    return mv;
  endfunction

  // millivolts per percent inside each segment
  function automatic logic [6:0] soc_step(input logic [4:0] seg);
    logic [6:0] st;
    case (seg)
      5'd0:    st = 7'd68;
      5'd1:    st = 7'd16;
      5'd2:    st = 7'd4;
      5'd3:    st = 7'd4;
      5'd4:    st = 7'd4;
      5'd5:    st = 7'd4;
      5'd6:    st = 7'd4;
      5'd7:    st = 7'd2;
      5'd8:    st = 7'd4;
      5'd9:    st = 7'd4;
      5'd10:   st = 7'd2;
      5'd11:   st = 7'd4;
      5'd12:   st = 7'd8;
      5'd13:   st = 7'd8;
      5'd14:   st = 7'd6;
      5'd15:   st = 7'd8;
      5'd16:   st = 7'd12;
      5'd17:   st = 7'd6;
      5'd18:   st = 7'd8;
      5'd19:   st = 7'd10;
      default: st = 7'd1;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

/* design/ctd_scale.sv */
// ---------------------------------------------------------------------------
// ctd_scale
// first stage: field unpacking and constant scaling of the adc codes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctd_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [7:0]      status_byte,
  input  wire logic [7:0]      fault_byte,
  input  wire logic [7:0]      bat_code,
  input  wire logic [7:0]      sys_code,
  input  wire logic [7:0]      vin_code,
  input  wire logic [7:0]      ichg_code,
  input  wire logic [7:0]      iin_code,
  input  wire logic [7:0]      ppm_byte,
  output logic                 s1_valid,
  output ctd_pkg::ctd_s1_t     s1_word
);
  import ctd_pkg::*;

  logic    valid_r;
  ctd_s1_t word_r;
  ctd_s1_t word_nxt;

  always_comb begin
    word_nxt.flags.input_state  = status_byte[7:5];
    word_nxt.flags.charge_state = status_byte[4:3];
    word_nxt.flags.fault_bits   = fault_byte[5:3];
    word_nxt.flags.ntc_state    = fault_byte[2:0];
    word_nxt.flags.ppm_bits     = ppm_byte[7:6];
    word_nxt.battery_mv         = {5'd0, bat_code} * MV_PER_VCODE;
    word_nxt.system_mv          = {5'd0, sys_code} * MV_PER_VCODE;
    word_nxt.input_mv           = {6'd0, vin_code[6:0]} * MV_PER_VIN;
    word_nxt.ichg_prod          = {8'd0, ichg_code} * ICHG_SCALE;
    word_nxt.iin_prod           = {8'd0, iin_code} * IIN_SCALE;
    word_nxt.limit_ma           = {6'd0, ppm_byte[5:0]} * MA_PER_LIMIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;

endmodule

`default_nettype wire

/* design/ctd_locate.sv */
// ---------------------------------------------------------------------------
// ctd_locate
// second stage: soc segment search and reciprocal multiply for the /10 terms
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctd_locate (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            s1_valid,
  input  wire ctd_pkg::ctd_s1_t s1_word,
  output logic                 s2_valid,
  output ctd_pkg::ctd_s2_t     s2_word
);
  import ctd_pkg::*;

  logic    valid_r;
  ctd_s2_t word_r;
  ctd_s2_t word_nxt;
  logic [4:0]  seg;
  logic [12:0] diff;

  always_comb begin
    seg = 5'd0;
    for (int k = SOC_FIRST_INNER; k <= SOC_LAST_INNER; k++) begin
      if (s1_word.battery_mv >= soc_point(5'(k))) begin
        seg = 5'(k);
      end
    end
    diff = s1_word.battery_mv - soc_point(seg);

    word_nxt.flags      = s1_word.flags;
    word_nxt.battery_mv = s1_word.battery_mv;
    word_nxt.system_mv  = s1_word.system_mv;
    word_nxt.input_mv   = s1_word.input_mv;
    word_nxt.ichg_recip = {16'd0, s1_word.ichg_prod} * RECIP_TEN;
    word_nxt.iin_recip  = {16'd0, s1_word.iin_prod} * RECIP_TEN;
    word_nxt.limit_ma   = s1_word.limit_ma;
    word_nxt.below      = s1_word.battery_mv < SOC_EMPTY_MV;
    word_nxt.full       = s1_word.battery_mv >= SOC_FULL_MV;
    word_nxt.seg        = seg;
    word_nxt.offset     = diff[8:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      word_r <= word_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2_word  = word_r;

endmodule

`default_nettype wire

/* design/ctd_finish.sv */
// ---------------------------------------------------------------------------
// ctd_finish
// third stage: in-segment percent, /10 shift and output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctd_finish (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s2_valid,
  input  wire ctd_pkg::ctd_s2_t s2_word,
  output logic                  out_strobe,
  output ctd_pkg::ctd_flags_t   out_flags,
  output logic [12:0]           out_battery_mv,
  output logic [12:0]           out_system_mv,
  output logic [12:0]           out_input_mv,
  output logic [12:0]           out_charge_ma,
  output logic [11:0]           out_input_ma,
  output logic [11:0]           out_limit_ma,
  output logic [6:0]            out_charge_percent
);
  import ctd_pkg::*;

  logic        strobe_r;
  ctd_flags_t  flags_r;
  logic [12:0] battery_mv_r;
  logic [12:0] system_mv_r;
  logic [12:0] input_mv_r;
  logic [12:0] charge_ma_r;
  logic [11:0] input_ma_r;
  logic [11:0] limit_ma_r;
  logic [6:0]  percent_r;
  logic [6:0]  percent_nxt;
  logic [6:0]  step;
  logic [2:0]  frac;
  logic [31:0] ichg_q;
  logic [31:0] iin_q;

  // offset / step, quotient is below five
  always_comb begin
    step = soc_step(s2_word.seg);
    frac = 3'd0;
    for (int j = 1; j < SOC_SUBSTEPS; j++) begin
      if (s2_word.offset >= 9'(step) * 9'(j)) begin
        frac = frac + 3'd1;
      end
    end
    if (s2_word.below) begin
      percent_nxt = PCT_EMPTY;
    end else if (s2_word.full) begin
      percent_nxt = PCT_FULL;
    end else begin
      percent_nxt = 7'(s2_word.seg) * 7'(SOC_SUBSTEPS) + {4'd0, frac};
    end
    ichg_q = s2_word.ichg_recip >> RECIP_SHIFT;
    iin_q  = s2_word.iin_recip >> RECIP_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      flags_r      <= s2_word.flags;
      battery_mv_r <= s2_word.battery_mv;
      system_mv_r  <= s2_word.system_mv;
      input_mv_r   <= s2_word.input_mv;
      charge_ma_r  <= ichg_q[12:0];
      input_ma_r   <= iin_q[11:0];
      limit_ma_r   <= s2_word.limit_ma;
      percent_r    <= percent_nxt;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_flags          = flags_r;
  assign out_battery_mv     = battery_mv_r;
  assign out_system_mv      = system_mv_r;
  assign out_input_mv       = input_mv_r;
  assign out_charge_ma      = charge_ma_r;
  assign out_input_ma       = input_ma_r;
  assign out_limit_ma       = limit_ma_r;
  assign out_charge_percent = percent_r;

endmodule

`default_nettype wire

/* design/charger_telemetry_decode.sv */
// ---------------------------------------------------------------------------
// charger_telemetry_decode
// decodes one snapshot of charger status and adc registers per word
// ---------------------------------------------------------------------------
//  channel   ports                      handshake
//  input     start, busy, in_*          taken when start && !busy
//  result    out_strobe, out_*          one cycle, no back-pressure
//
//  three register stages: scale, segment search with /10 multiply, finish
//  a word taken at edge n shows on the result ports in the cycle after edge n+2
//  a new word may be taken at every edge, so one word per cycle sustained
//  busy is high only while rst_n is low; reset empties all three stages
//  results cannot be held off, so nothing in the pipe ever stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module charger_telemetry_decode (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_status_byte,
  input  wire logic [7:0] in_fault_byte,
  input  wire logic [7:0] in_bat_code,
  input  wire logic [7:0] in_sys_code,
  input  wire logic [7:0] in_vin_code,
  input  wire logic [7:0] in_ichg_code,
  input  wire logic [7:0] in_iin_code,
  input  wire logic [7:0] in_ppm_byte,
  output logic            out_strobe,
  output logic [2:0]      out_input_state,
  output logic [1:0]      out_charge_state,
  output logic [2:0]      out_fault_bits,
  output logic [2:0]      out_ntc_state,
  output logic [1:0]      out_ppm_bits,
  output logic [12:0]     out_battery_mv,
  output logic [12:0]     out_system_mv,
  output logic [12:0]     out_input_mv,
  output logic [12:0]     out_charge_ma,
  output logic [11:0]     out_input_ma,
  output logic [11:0]     out_limit_ma,
  output logic [6:0]      out_charge_percent
);
  import ctd_pkg::*;

  logic       in_take;
  logic       s1_valid;
  ctd_s1_t    s1_word;
  logic       s2_valid;
  ctd_s2_t    s2_word;
  ctd_flags_t flags;

  assign busy    = !rst_n;
  assign in_take = start && !busy;

  ctd_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_take),
    .status_byte (in_status_byte),
    .fault_byte  (in_fault_byte),
    .bat_code    (in_bat_code),
    .sys_code    (in_sys_code),
    .vin_code    (in_vin_code),
    .ichg_code   (in_ichg_code),
    .iin_code    (in_iin_code),
    .ppm_byte    (in_ppm_byte),
    .s1_valid    (s1_valid),
    .s1_word     (s1_word)
  );

  ctd_locate u_locate (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_word  (s1_word),
    .s2_valid (s2_valid),
    .s2_word  (s2_word)
  );

  ctd_finish u_finish (
    .clk                (clk),
    .rst_n              (rst_n),
    .s2_valid           (s2_valid),
    .s2_word            (s2_word),
    .out_strobe         (out_strobe),
    .out_flags          (flags),
    .out_battery_mv     (out_battery_mv),
    .out_system_mv      (out_system_mv),
    .out_input_mv       (out_input_mv),
    .out_charge_ma      (out_charge_ma),
    .out_input_ma       (out_input_ma),
    .out_limit_ma       (out_limit_ma),
    .out_charge_percent (out_charge_percent)
  );

  assign out_input_state  = flags.input_state;
  assign out_charge_state = flags.charge_state;
  assign out_fault_bits   = flags.fault_bits;
  assign out_ntc_state    = flags.ntc_state;
  assign out_ppm_bits     = flags.ppm_bits;

endmodule

`default_nettype wire

/* design/ctd_checker.sv */
// ---------------------------------------------------------------------------
// ctd_checker
// port-level checks on latency and state of charge limits, bound to the top
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "charger_telemetry_decode_macros.svh"

module ctd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic [12:0] out_battery_mv,
  input wire logic [6:0]  out_charge_percent
);
  import ctd_pkg::*;

  logic in_take;
  assign in_take = start && !busy;

  `CTD_ASSERT(a_word_out, clk, rst_n, in_take |-> ##3 out_strobe, "word taken but no result")
  `CTD_ASSERT(a_no_spurious, clk, rst_n, out_strobe |-> $past(in_take, 3), "result without word")
  `CTD_ASSERT(a_empty, clk, rst_n, (out_strobe && out_battery_mv < SOC_EMPTY_MV) |-> out_charge_percent == PCT_EMPTY, "charge not zero below table")
  `CTD_ASSERT(a_full, clk, rst_n, (out_strobe && out_battery_mv >= SOC_FULL_MV) |-> out_charge_percent == PCT_FULL, "charge not full at top of table")
  `CTD_ASSERT_ALWAYS(a_pct_range, clk, out_strobe |-> out_charge_percent <= PCT_FULL, "charge above full")

endmodule

bind charger_telemetry_decode ctd_checker u_ctd_checker (.*);

`default_nettype wire

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// drives charger register snapshots into charger_telemetry_decode in bursts
// with random gaps, predicts each decoded reading (bit fields, scaled volts
// and amps, piecewise-linear state of charge) and checks every strobed
// result against the oldest pending prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RANDOM_WORDS = 1130;
  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned PIPE_TAIL    = 8;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] fault_byte;
    logic [7:0] bat_code;
    logic [7:0] sys_code;
    logic [7:0] vin_code;
    logic [7:0] ichg_code;
    logic [7:0] iin_code;
    logic [7:0] ppm_byte;
  } snapshot_t;

  typedef struct packed {
    logic [2:0]  input_state;
    logic [1:0]  charge_state;
    logic [2:0]  fault_bits;
    logic [2:0]  ntc_state;
    logic [1:0]  ppm_bits;
    logic [12:0] battery_mv;
    logic [12:0] system_mv;
    logic [12:0] input_mv;
    logic [12:0] charge_ma;
    logic [11:0] input_ma;
    logic [11:0] limit_ma;
    logic [6:0]  charge_percent;
  } reading_t;

  class telemetry_scoreboard;
    reading_t    pending_readings[$];
    int unsigned mismatches;
    int unsigned soc_mv[21];

    function new();
      mismatches = 0;
      soc_mv = '{3270, 3610, 3690, 3710, 3730, 3750, 3770, 3790, 3800, 3820, 3840,
                 3850, 3870, 3910, 3950, 3980, 4020, 4080, 4110, 4150, 4200};
    endfunction

    function int unsigned state_of_charge(int unsigned mv);
      int unsigned seg;
      int unsigned width;
      seg = 0;
      if (mv < soc_mv[0]) return 0;
      if (mv >= soc_mv[20]) return 100;
      for (int k = 1; k < 20; k++) begin
        if (mv >= soc_mv[k]) seg = k;
      end
      width = (soc_mv[seg + 1] - soc_mv[seg]) / 5;
      return seg * 5 + (mv - soc_mv[seg]) / width;
    endfunction

    function reading_t decode_snapshot(snapshot_t s);
      reading_t    r;
      int unsigned bat_mv;
      bat_mv           = 32'(s.bat_code) * 20;
      r.input_state    = s.status_byte[7:5];
      r.charge_state   = s.status_byte[4:3];
      r.fault_bits     = s.fault_byte[5:3];
      r.ntc_state      = s.fault_byte[2:0];
      r.ppm_bits       = s.ppm_byte[7:6];
      r.battery_mv     = 13'(bat_mv);
      r.system_mv      = 13'(32'(s.sys_code) * 20);
      r.input_mv       = 13'(32'(s.vin_code[6:0]) * 60);
      r.charge_ma      = 13'((32'(s.ichg_code) * 175) / 10);
      r.input_ma       = 12'((32'(s.iin_code) * 133) / 10);
      r.limit_ma       = 12'(32'(s.ppm_byte[5:0]) * 50);
      r.charge_percent = 7'(state_of_charge(bat_mv));
      return r;
    endfunction

    function void note_snapshot(snapshot_t s);
      pending_readings.push_back(decode_snapshot(s));
    endfunction

    function void check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, actual %h", $time, got);
        return;
      end
      want = pending_readings.pop_front();
      check_field("input_state", want.input_state, got.input_state);
      check_field("charge_state", want.charge_state, got.charge_state);
      check_field("fault_bits", want.fault_bits, got.fault_bits);
      check_field("ntc_state", want.ntc_state, got.ntc_state);
      check_field("ppm_bits", want.ppm_bits, got.ppm_bits);
      check_field("battery_mv", want.battery_mv, got.battery_mv);
      check_field("system_mv", want.system_mv, got.system_mv);
      check_field("input_mv", want.input_mv, got.input_mv);
      check_field("charge_ma", want.charge_ma, got.charge_ma);
      check_field("input_ma", want.input_ma, got.input_ma);
      check_field("limit_ma", want.limit_ma, got.limit_ma);
      check_field("charge_percent", want.charge_percent, got.charge_percent);
    endfunction

    function int unsigned outstanding();
      return pending_readings.size();
    endfunction
  endclass

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  snapshot_t   snap  = '0;
  reading_t    seen;
  logic        out_strobe;
  int unsigned idle_cycles = 0;

  telemetry_scoreboard sb = new();

  always #1 clk = ~clk;

  charger_telemetry_decode DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_status_byte     (snap.status_byte),
    .in_fault_byte      (snap.fault_byte),
    .in_bat_code        (snap.bat_code),
    .in_sys_code        (snap.sys_code),
    .in_vin_code        (snap.vin_code),
    .in_ichg_code       (snap.ichg_code),
    .in_iin_code        (snap.iin_code),
    .in_ppm_byte        (snap.ppm_byte),
    .out_strobe         (out_strobe),
    .out_input_state    (seen.input_state),
    .out_charge_state   (seen.charge_state),
    .out_fault_bits     (seen.fault_bits),
    .out_ntc_state      (seen.ntc_state),
    .out_ppm_bits       (seen.ppm_bits),
    .out_battery_mv     (seen.battery_mv),
    .out_system_mv      (seen.system_mv),
    .out_input_mv       (seen.input_mv),
    .out_charge_ma      (seen.charge_ma),
    .out_input_ma       (seen.input_ma),
    .out_limit_ma       (seen.limit_ma),
    .out_charge_percent (seen.charge_percent)
  );

  // accepted words and strobed results, sampled before this edge's updates
  always @(posedge clk) begin
    if (start && busy === 1'b0) sb.note_snapshot(snap);
    if (out_strobe === 1'b1) sb.check_reading(seen);
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic snapshot_t random_snapshot();
    snapshot_t s;
    s = {$urandom, $urandom};
    // keep half the battery codes around the charge table
    if ($urandom_range(0, 1) == 0) s.bat_code = 8'($urandom_range(160, 212));
    return s;
  endfunction

  task automatic send_word(input snapshot_t s);
    start <= 1'b1;
    snap  <= s;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    snap  <= random_snapshot();
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word('0);
    send_word({8{8'hff}});
    send_word({8{8'h55}});
    send_word({8{8'haa}});
    send_word({8'h80, 8'h20, 8'd163, 8'd0, 8'h80, 8'd1, 8'd1, 8'hc0});
    send_word({8'h40, 8'h10, 8'd164, 8'd255, 8'h7f, 8'd2, 8'd2, 8'h3f});
    send_word({8'h20, 8'h08, 8'd180, 8'd1, 8'h01, 8'd3, 8'd3, 8'h80});
    send_word({8'h10, 8'h04, 8'd181, 8'd128, 8'h40, 8'd128, 8'd128, 8'h40});
    send_word({8'h08, 8'h02, 8'd184, 8'd7, 8'hfe, 8'd254, 8'd254, 8'h01});
    send_word({8'h04, 8'h01, 8'd190, 8'd9, 8'h3c, 8'd10, 8'd10, 8'h20});
    send_word({8'h02, 8'h38, 8'd191, 8'd11, 8'h00, 8'd99, 8'd77, 8'h10});
    send_word({8'h01, 8'h07, 8'd192, 8'd13, 8'h55, 8'd100, 8'd200, 8'h08});
    send_word({8'he0, 8'hc0, 8'd196, 8'd15, 8'h2a, 8'd64, 8'd32, 8'h04});
    send_word({8'h18, 8'h3f, 8'd201, 8'd17, 8'h11, 8'd5, 8'd7, 8'h02});
    send_word({8'h07, 8'h00, 8'd204, 8'd19, 8'h22, 8'd6, 8'd9, 8'hff});
    send_word({8'h5a, 8'h5a, 8'd207, 8'd21, 8'h33, 8'd200, 8'd250, 8'h7e});
    send_word({8'ha5, 8'ha5, 8'd209, 8'd23, 8'h44, 8'd11, 8'd13, 8'hbf});
    send_word({8'h3c, 8'hc3, 8'd210, 8'd25, 8'h66, 8'd12, 8'd14, 8'h00});
    send_word({8'hc3, 8'h3c, 8'd211, 8'd27, 8'h77, 8'd255, 8'd0, 8'h81});
    send_word({8'h00, 8'hff, 8'd255, 8'd250, 8'hff, 8'd0, 8'd255, 8'h41});
    drain_pipe();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 32);
      for (int unsigned i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
        send_word(random_snapshot());
        sent++;
      end
      // an unbroken stretch first, then a short or long gap after most bursts
      if (sent > 150) begin
        case ($urandom_range(0, 7))
          0, 1:    ;
          2:       hold_off($urandom_range(8, 16));
          default: hold_off($urandom_range(1, 5));
        endcase
      end
      if (sent >= 600 && sent < 600 + burst) drain_pipe();
    end

    drain_pipe();
    repeat (PIPE_TAIL) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ctd_pkg.sv
design/ctd_scale.sv
design/ctd_locate.sv
design/ctd_finish.sv
design/charger_telemetry_decode.sv
design/ctd_checker.sv
tb/sv/testbench.sv
